/* rtl/core/json_string_escape_macros.svh */
// Assertion macros for the JSON string escaper RTL.
`ifndef JSON_STRING_ESCAPE_MACROS_SVH
`define JSON_STRING_ESCAPE_MACROS_SVH

// Concurrent check on clk_i, quiet while rst_ni is low.
`define JSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: when ante holds, cons must hold in the same cycle.
`define JSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  `JSE_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/core/jse_pkg.sv */
// Package: character codes, descriptor type and helper functions of the JSON escaper.
`default_nettype none

package jse_pkg;

  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U         = 8'h75;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_CTRL_LIM  = 8'h20;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  // Body lengths of each class of byte.
  localparam logic [2:0] LEN_PLAIN   = 3'd1;
  localparam logic [2:0] LEN_NAMED   = 3'd2;
  localparam logic [2:0] LEN_UNICODE = 3'd6;
  localparam logic [2:0] LEN_EMPTY   = 3'd0;

  typedef enum logic [1:0] {
    CLS_PLAIN   = 2'd0,
    CLS_NAMED   = 2'd1,
    CLS_UNICODE = 2'd2,
    CLS_EMPTY   = 2'd3
  } class_e;

  // One classified item as handed from the front to the back.
  typedef struct packed {
    class_e     cls;
    logic [7:0] data;
    logic [7:0] esc;       // second byte of a two-byte escape
    logic       has_open;
    logic       has_close;
    logic [2:0] body_len;
    logic [2:0] last_idx;  // index of the final result byte
  } desc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h57 + {4'd0, nib};
    end
    return r;
  endfunction

  function automatic desc_t classify(input logic [7:0] b, input logic st,
                                     input logic en, input logic emp);
    desc_t      d;
    logic [3:0] total;
    d.data = b;
    d.esc  = 8'h00;
    if (emp) begin
      d.cls = CLS_EMPTY;
    end else begin
      case (b)
        CHAR_QUOTE, CHAR_BACKSLASH: begin
          d.cls = CLS_NAMED;
          d.esc = b;
        end
        8'h08: begin
          d.cls = CLS_NAMED;
          d.esc = 8'h62;
        end
        8'h0C: begin
          d.cls = CLS_NAMED;
          d.esc = 8'h66;
        end
        8'h0A: begin
          d.cls = CLS_NAMED;
          d.esc = 8'h6E;
        end
        8'h0D: begin
          d.cls = CLS_NAMED;
          d.esc = 8'h72;
        end
        8'h09: begin
          d.cls = CLS_NAMED;
          d.esc = 8'h74;
        end
        default: begin
          d.cls = (b < CHAR_CTRL_LIM) ? CLS_UNICODE : CLS_PLAIN;
        end
      endcase
    end
    case (d.cls)
      CLS_PLAIN:   d.body_len = LEN_PLAIN;
      CLS_NAMED:   d.body_len = LEN_NAMED;
      CLS_UNICODE: d.body_len = LEN_UNICODE;
      default:     d.body_len = LEN_EMPTY;
    endcase
    d.has_open  = emp | st;
    d.has_close = emp | en;
    total = {3'd0, d.has_open} + {1'b0, d.body_len} + {3'd0, d.has_close} - 4'd1;
    d.last_idx = total[2:0];
    return d;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/jse_if.sv */
// Interfaces: input byte channel and output text channel of the JSON escaper.
`default_nettype none

interface jse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       string_start;
  logic       string_end;
  logic       empty_string;

  modport source (output valid, data_byte, string_start, string_end, empty_string,
                  input ready);
  modport sink   (input valid, data_byte, string_start, string_end, empty_string,
                  output ready);
endinterface

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       literal_done;

  modport source (output valid, out_byte, run_last, literal_done, input ready);
  modport sink   (input valid, out_byte, run_last, literal_done, output ready);
endinterface

`default_nettype wire

/* rtl/core/jse_front.sv */
// Front stage: accept input transactions and classify each byte into a descriptor.
`default_nettype none

module jse_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  jse_in_if.sink             in_i,
  output jse_pkg::desc_t     push_data_o,
  output logic               push_valid_o,
  input  wire logic          push_ready_i
);
  import jse_pkg::*;

  logic  valid_q, valid_d;
  desc_t desc_q;

  assign in_i.ready = !valid_q || push_ready_i;
  assign valid_d    = in_i.ready ? in_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      desc_q <= classify(in_i.data_byte, in_i.string_start, in_i.string_end,
                         in_i.empty_string);
    end
  end

  assign push_valid_o = valid_q;
  assign push_data_o  = desc_q;

endmodule

`default_nettype wire

/* rtl/core/jse_fifo.sv */
// Descriptor queue between the front and the back stage.
`default_nettype none

module jse_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  jse_pkg::desc_t      push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output jse_pkg::desc_t      pop_data_o
);
  import jse_pkg::*;

  localparam logic [FIFO_AW-1:0] PtrMax = FIFO_AW'(FIFO_DEPTH - 1);
  localparam logic [FIFO_AW:0]   CntMax = (FIFO_AW + 1)'(FIFO_DEPTH);

  desc_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = (cnt_q != CntMax);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/jse_back.sv */
// Back stage: expand one descriptor into its output bytes, one per cycle while out_o.ready allows.
`default_nettype none

module jse_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       pop_valid_i,
  output logic            pop_ready_o,
  input  jse_pkg::desc_t  pop_data_i,
  jse_out_if.source       out_o
);
  import jse_pkg::*;
  `include "json_string_escape_macros.svh"

  logic       load_en, emit, at_last;
  logic [2:0] step_q, step_d;
  logic [2:0] body_idx;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, byte_d;
  logic       run_last_q, done_q, done_d;

  assign load_en     = !out_valid_q || out_o.ready;
  assign emit        = pop_valid_i && load_en;
  assign at_last     = (step_q == pop_data_i.last_idx);
  assign pop_ready_o = load_en && at_last;
  assign body_idx    = step_q - {2'b00, pop_data_i.has_open};

  // Pick the byte at the current step: open quote, body, close quote.
  always_comb begin
    done_d = 1'b0;
    if (pop_data_i.has_open && step_q == 3'd0) begin
      byte_d = CHAR_QUOTE;
    end else if (body_idx < pop_data_i.body_len) begin
      case (pop_data_i.cls)
        CLS_NAMED: begin
          byte_d = (body_idx == 3'd0) ? CHAR_BACKSLASH : pop_data_i.esc;
        end
        CLS_UNICODE: begin
          case (body_idx)
            3'd0:    byte_d = CHAR_BACKSLASH;
            3'd1:    byte_d = CHAR_U;
            3'd4:    byte_d = hex_digit(pop_data_i.data[7:4]);
            3'd5:    byte_d = hex_digit(pop_data_i.data[3:0]);
            default: byte_d = CHAR_ZERO;
          endcase
        end
        default: byte_d = pop_data_i.data;
      endcase
    end else begin
      byte_d = CHAR_QUOTE;
      done_d = 1'b1;
    end
  end

  assign out_valid_d = load_en ? pop_valid_i : out_valid_q;

  always_comb begin
    step_d = step_q;
    if (emit) begin
      step_d = at_last ? 3'd0 : step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= 3'd0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= byte_d;
      run_last_q <= at_last;
      done_q     <= done_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.run_last     = run_last_q;
  assign out_o.literal_done = done_q;

  `JSE_ASSERT_IMPL(a_step_in_range, pop_valid_i, step_q <= pop_data_i.last_idx, "step past end")
  `JSE_ASSERT_IMPL(a_done_is_quote, out_valid_q && done_q, out_byte_q == CHAR_QUOTE, "done on non-quote")
  `JSE_ASSERT_IMPL(a_done_is_last, out_valid_q && done_q, run_last_q, "done before run end")
  `JSE_ASSERT_IMPL(a_step_idle_zero, !pop_valid_i, step_q == 3'd0, "step left mid item")

endmodule

`default_nettype wire

/* rtl/core/json_string_escape.sv */
// Top level of the JSON string escaper: front classifier, descriptor queue, byte expander.
// Each input byte is registered as a descriptor, queued, then registered at the output.
// Throughput: one result byte per cycle while out_o.ready is high; an item with n results
// (1 to 8) holds the expander for all of them, so plain middle bytes run at one per cycle.
// Reset: rst_ni low clears all valid flags, queue pointers and the step counter at once.
`default_nettype none

module json_string_escape (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jse_in_if.sink    in_i,
  jse_out_if.source out_o
);
  import jse_pkg::*;

  // Front to queue: classified descriptors, one per input transaction.
  desc_t push_data;
  logic  push_valid, push_ready;

  // Queue to back: oldest descriptor waits here until its last byte is sent.
  desc_t pop_data;
  logic  pop_valid, pop_ready;

  // Classify each byte and register it; accept again as soon as the queue takes it.
  jse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_data_o  (push_data),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  // Decouple the one-byte-in front from the multi-byte-out back.
  jse_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Walk the descriptor step by step into the registered output channel.
  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
